// ===== sv/dfcd_pkg.sv =====
// ----------------------------------------------------------------------------
// dfcd_pkg
// Types and constants shared by the date format code detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dfcd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // "[$-F400]" and "[$-F800]", first character in the high byte
  localparam logic [63:0] LOCALE_TAG_F400 = 64'h5B242D463430305D;
  localparam logic [63:0] LOCALE_TAG_F800 = 64'h5B242D463830305D;

  localparam logic [15:0] PAT_YY    = 16'h7979;
  localparam logic [15:0] PAT_DD    = 16'h6464;
  localparam logic [15:0] PAT_MM    = 16'h6D6D;
  localparam logic [15:0] PAT_M_SL  = 16'h6D2F;
  localparam logic [15:0] PAT_SL_M  = 16'h2F6D;
  localparam logic [7:0]  PAT_H     = 8'h68;
  localparam logic [15:0] PAT_SS    = 16'h7373;
  localparam logic [23:0] PAT_A_P   = 24'h612F70;
  localparam logic [39:0] PAT_AM_PM = 40'h616D2F706D;

  // Classified byte handed from the front end to the back end
  typedef struct packed {
    logic       keep;
    logic [7:0] kbyte;
    logic       nonspace;
    logic       locale_hit;
    logic       last;
    logic       empty;
  } token_t;

endpackage

`default_nettype wire

// ===== sv/date_format_code_detector.sv =====
// ----------------------------------------------------------------------------
// date_format_code_detector
// Decides whether a spreadsheet number-format code denotes a date or time.
//
//   channel | ports                                                   | dir
//   --------+---------------------------------------------------------+-----
//   input   | in_valid in_stall in_code_byte in_last_byte in_empty_code | in
//   result  | out_valid out_stall out_is_date                         | out
//
// One byte per cycle is accepted while in_stall is low; the front end classifies it in the
// accept cycle and the back end consumes one token per cycle from the queue, except that a
// last (or empty) token waits while a stalled verdict is pending. Its verdict is registered
// into out_valid/out_is_date when the back end pops it from the token queue.
// in_stall is high only when the token queue is full.
// Reset (rst_n low, synchronous) clears all flags, the queue and out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module date_format_code_detector #(
  parameter int unsigned QUEUE_DEPTH = dfcd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_code_byte,
  input  wire logic        in_last_byte,
  input  wire logic        in_empty_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_date
);

  dfcd_pkg::token_t front_tok;
  dfcd_pkg::token_t back_tok;
  logic             accept;
  logic             full;
  logic             q_empty;
  logic             pop;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  dfcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .code_byte  (in_code_byte),
    .last_byte  (in_last_byte),
    .empty_code (in_empty_code),
    .tok        (front_tok)
  );

  dfcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_tok (front_tok),
    .full     (full),
    .pop      (pop),
    .q_empty  (q_empty),
    .pop_tok  (back_tok)
  );

  dfcd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .tok         (back_tok),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_is_date (out_is_date)
  );

endmodule

`default_nettype wire

// ===== sv/dfcd_front.sv =====
// ----------------------------------------------------------------------------
// dfcd_front
// Accepts format code bytes, tracks quote/bracket/skip state and the raw
// window, and emits one classified token per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module dfcd_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [7:0]      code_byte,
  input  wire logic            last_byte,
  input  wire logic            empty_code,
  output dfcd_pkg::token_t     tok
);

  logic        quote_r, quote_nxt;
  logic        bracket_r, bracket_nxt;
  logic        skip_r, skip_nxt;
  logic [55:0] raw_r, raw_nxt;
  logic [63:0] rw;
  logic        keep;
  logic        upper;

  always_comb begin
    rw          = {raw_r, code_byte};
    quote_nxt   = quote_r;
    bracket_nxt = bracket_r;
    skip_nxt    = skip_r;
    keep        = 1'b0;
    if (skip_r) begin
      skip_nxt = 1'b0;
    end else if (code_byte == dfcd_pkg::CH_QUOTE) begin
      quote_nxt = !quote_r;
    end else if (quote_r) begin
      keep = 1'b0;
    end else if (code_byte == dfcd_pkg::CH_LBRACK) begin
      bracket_nxt = 1'b1;
    end else if (code_byte == dfcd_pkg::CH_RBRACK && bracket_r) begin
      bracket_nxt = 1'b0;
    end else if (bracket_r) begin
      keep = 1'b1;
    end else if (code_byte == dfcd_pkg::CH_BSLASH || code_byte == dfcd_pkg::CH_USCORE) begin
      skip_nxt = 1'b1;
    end else if (code_byte == dfcd_pkg::CH_STAR) begin
      keep = 1'b0;
    end else begin
      keep = 1'b1;
    end
    raw_nxt = rw[55:0];
    upper   = (code_byte >= dfcd_pkg::CH_UPPER_A) && (code_byte <= dfcd_pkg::CH_UPPER_Z);

    tok.keep       = keep && !empty_code;
    tok.kbyte      = upper ? (code_byte + dfcd_pkg::CASE_DELTA) : code_byte;
    tok.nonspace   = !(code_byte == dfcd_pkg::CH_SPACE ||
                       (code_byte >= dfcd_pkg::CH_TAB && code_byte <= dfcd_pkg::CH_CR));
    tok.locale_hit = (rw == dfcd_pkg::LOCALE_TAG_F400) || (rw == dfcd_pkg::LOCALE_TAG_F800);
    tok.last       = last_byte && !empty_code;
    tok.empty      = empty_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r   <= 1'b0;
      bracket_r <= 1'b0;
      skip_r    <= 1'b0;
      raw_r     <= '0;
    end else if (accept) begin
      if (empty_code || last_byte) begin
        quote_r   <= 1'b0;
        bracket_r <= 1'b0;
        skip_r    <= 1'b0;
        raw_r     <= '0;
      end else begin
        quote_r   <= quote_nxt;
        bracket_r <= bracket_nxt;
        skip_r    <= skip_nxt;
        raw_r     <= raw_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/dfcd_queue.sv =====
// ----------------------------------------------------------------------------
// dfcd_queue
// Short token queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dfcd_queue #(
  parameter int unsigned DEPTH = dfcd_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire dfcd_pkg::token_t push_tok,
  output logic                  full,
  input  wire logic             pop,
  output logic                  q_empty,
  output dfcd_pkg::token_t      pop_tok
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dfcd_pkg::token_t   mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_empty = (count_r == '0);
  assign pop_tok = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dfcd_back.sv =====
// ----------------------------------------------------------------------------
// dfcd_back
// Matches kept bytes against date/time patterns, accumulates the verdict
// flags and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dfcd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire dfcd_pkg::token_t tok,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_is_date
);

  logic [31:0] hist_r;
  logic        pattern_r, locale_r, nonspace_r;
  logic        valid_r, valid_nxt;
  logic        is_date_r;
  logic [39:0] w;
  logic        pat_hit;
  logic        pattern_nxt, locale_nxt, nonspace_nxt;
  logic        emits;

  assign emits = tok.last || tok.empty;
  assign pop   = !q_empty && (!emits || !valid_r || !out_stall);

  always_comb begin
    w       = {hist_r, tok.kbyte};
    pat_hit = (w[15:0] == dfcd_pkg::PAT_YY)   || (w[15:0] == dfcd_pkg::PAT_DD)  ||
              (w[15:0] == dfcd_pkg::PAT_MM)   || (w[15:0] == dfcd_pkg::PAT_M_SL) ||
              (w[15:0] == dfcd_pkg::PAT_SL_M) || (w[7:0] == dfcd_pkg::PAT_H)    ||
              (w[15:0] == dfcd_pkg::PAT_SS)   || (w[23:0] == dfcd_pkg::PAT_A_P) ||
              (w == dfcd_pkg::PAT_AM_PM);
    pattern_nxt  = pattern_r || (tok.keep && pat_hit);
    locale_nxt   = locale_r || tok.locale_hit;
    nonspace_nxt = nonspace_r || tok.nonspace;

    valid_nxt = valid_r;
    if (pop && emits) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emits) begin
      is_date_r <= !tok.empty && nonspace_nxt && (locale_nxt || pattern_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      hist_r     <= '0;
      pattern_r  <= 1'b0;
      locale_r   <= 1'b0;
      nonspace_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (pop) begin
        if (emits) begin
          hist_r     <= '0;
          pattern_r  <= 1'b0;
          locale_r   <= 1'b0;
          nonspace_r <= 1'b0;
        end else begin
          if (tok.keep) begin
            hist_r <= w[31:0];
          end
          pattern_r  <= pattern_nxt;
          locale_r   <= locale_nxt;
          nonspace_r <= nonspace_nxt;
        end
      end
    end
  end

  assign out_valid   = valid_r;
  assign out_is_date = is_date_r;

endmodule

`default_nettype wire

// ===== sv/dfcd_checker.sv =====
// ----------------------------------------------------------------------------
// dfcd_checker
// Port-level checks on the date format code detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dfcd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_code_byte,
  input wire logic       in_last_byte,
  input wire logic       in_empty_code,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_is_date
);

  // no verdict is pending right after reset
  a_out_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // queue is empty after reset, so input is open
  a_in_open_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("in_stall high after reset");

  // a stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_is_date))
    else $error("stalled verdict changed");

  // a stalled input transaction holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=>
      in_valid && $stable({in_code_byte, in_last_byte, in_empty_code}))
    else $error("stalled input transaction changed");

endmodule

bind date_format_code_detector dfcd_checker u_dfcd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_code_byte  (in_code_byte),
  .in_last_byte  (in_last_byte),
  .in_empty_code (in_empty_code),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_is_date   (out_is_date)
);

`default_nettype wire
